@@ sv/mfvd_pkg.sv @@
// Shared types and constants of the marker frame value decoder.
`default_nettype none

package mfvd_pkg;

  // Widths of the item fields.
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 17;
  localparam int unsigned CfgIdxW = 2;

  // Operation codes carried in the op field.
  localparam logic [OpW-1:0] OP_BYTE  = 2'd0;
  localparam logic [OpW-1:0] OP_ACK   = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_MARKER   = 2'd1;

  // Reset values of the markers.
  localparam logic [ByteW-1:0] StartMarkerRst = 8'h53;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'h43;

  // Payload decoding.
  localparam int unsigned     DecodeBytes = 4;
  localparam logic [ByteW-1:0] ModeValue  = 8'd1;
  localparam logic [ByteW-1:0] ModeClass  = 8'd2;
  localparam logic [ByteW-1:0] NegCode    = 8'd2;

  // Depth of the command queue and of the result queue.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_ACK,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             is_start;
    logic             is_end;
  } cmd_t;

  // Result item as it leaves the block.
  typedef struct packed {
    logic              frame_ready;
    logic [ValueW-1:0] value;
    logic [ByteW-1:0]  class_code;
    logic              collecting;
  } res_t;

endpackage

`default_nettype wire

@@ sv/marker_frame_value_decoder.sv @@
// Top level of the marker frame value decoder.
//
// Items enter through a queue-like port: op_i and rx_byte_i are taken at a
// clock edge where push is high and full is low. Op 0 is a received byte,
// op 1 acknowledges a decoded frame, op 2 clears the class code.
// Every item yields exactly one result item, which shows the state after
// that item: frame_ready_o, signed_value_o, class_code_o and collecting_o.
// The oldest result sits on the result ports while empty is low and is
// taken at an edge where pop is high and empty is low.
// An accepted item is registered in the command queue and then in the result
// queue before empty goes low; throughput is one item per cycle while the
// result queue is not full, set by the frame state update in the back part. A two-entry
// command queue and a two-entry result queue sit on either side of that part.
// Marker registers are written through cfg_valid_i, cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Index 0 is the start marker,
// index 1 the end marker; other indexes are ignored.
// Reset sets the markers to 0x53 and 0x43, clears the frame state and
// empties both queues. When pop stays low the result queue fills, the back
// part stops, the command queue fills and full rises.
`default_nettype none

module marker_frame_value_decoder
  import mfvd_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [OpW-1:0]           op_i,
  input  logic [ByteW-1:0]         rx_byte_i,
  output logic                     empty,
  input  logic                     pop,
  output logic                     frame_ready_o,
  output logic signed [ValueW-1:0] signed_value_o,
  output logic [ByteW-1:0]         class_code_o,
  output logic                     collecting_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [ByteW-1:0]         cfg_data_i
);

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  res_t res;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  mfvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .op_i        (op_i),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  mfvd_back #(
    .BufferDepth (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .res_o       (res),
    .empty_o     (empty)
  );

  // The result fields come straight from the head of the result queue.
  assign frame_ready_o  = res.frame_ready;
  assign signed_value_o = $signed(res.value);
  assign class_code_o   = res.class_code;
  assign collecting_o   = res.collecting;

endmodule

`default_nettype wire

@@ sv/mfvd_fifo.sv @@
// Small first-in first-out queue used for the command and result queues of the decoder.
`default_nettype none

module mfvd_fifo
  import mfvd_pkg::*;
#(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/mfvd_front.sv @@
// Front part: holds the marker registers, classifies each item and queues it.
`default_nettype none

module mfvd_front
  import mfvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [OpW-1:0]     op_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               full_o,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               cmd_pop_i,
  output cmd_t               cmd_o,
  output logic               cmd_empty_o
);

  logic [ByteW-1:0] start_marker_q, end_marker_q;
  cmd_t             cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      end_marker_q   <= EndMarkerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_MARKER: start_marker_q <= cfg_data_i;
        CFG_END_MARKER:   end_marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_in.data     = rx_byte_i;
    cmd_in.is_start = (rx_byte_i == start_marker_q);
    cmd_in.is_end   = (rx_byte_i == end_marker_q);
    case (op_i)
      OP_BYTE:  cmd_in.kind = CMD_BYTE;
      OP_ACK:   cmd_in.kind = CMD_ACK;
      OP_CLEAR: cmd_in.kind = CMD_CLEAR;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  mfvd_fifo #(
    .Width ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

`default_nettype wire

@@ sv/mfvd_back.sv @@
// Back part: frame state, payload bytes, decoding and the result queue.
`default_nettype none

module mfvd_back
  import mfvd_pkg::*;
#(
  parameter int unsigned BufferDepth = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output res_t res_o,
  output logic empty_o
);

  localparam int unsigned IdxW = $clog2(BufferDepth + 1);

  // Only the leading bytes are ever decoded, so only those are kept.
  logic [ByteW-1:0]  store_q [DecodeBytes];
  logic [ByteW-1:0]  store_d [DecodeBytes];
  logic [IdxW-1:0]   idx_q, idx_d, idx_inc;
  logic              in_frame_q, in_frame_d;
  logic              ready_q, ready_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [ByteW-1:0]  class_q, class_d;

  logic              exec, out_full;
  logic [ValueW-1:0] dec_raw, dec_value;
  logic [ByteW-1:0]  dec_class;
  res_t              res_in;
  logic [$bits(res_t)-1:0] res_raw;

  assign exec      = !cmd_empty_i && !out_full;
  assign cmd_pop_o = exec;
  assign idx_inc   = idx_q + 1'b1;

  always_comb begin
    dec_raw   = {1'b0, store_q[2], store_q[3]};
    dec_value = '0;
    dec_class = '0;
    if (store_q[0] == ModeValue) begin
      dec_value = (store_q[1] == NegCode) ? (~dec_raw + ValueW'(1)) : dec_raw;
    end else if (store_q[0] == ModeClass) begin
      dec_class = store_q[1];
    end
  end

  always_comb begin
    store_d    = store_q;
    idx_d      = idx_q;
    in_frame_d = in_frame_q;
    ready_d    = ready_q;
    value_d    = value_q;
    class_d    = class_q;
    if (exec) begin
      case (cmd_i.kind)
        CMD_BYTE: begin
          if (!ready_q) begin
            if (in_frame_q) begin
              if (cmd_i.is_end) begin
                ready_d    = 1'b1;
                value_d    = dec_value;
                class_d    = dec_class;
                in_frame_d = 1'b0;
              end else begin
                for (int i = 0; i < DecodeBytes; i++) begin
                  if (idx_q == IdxW'(i)) begin
                    store_d[i] = cmd_i.data;
                  end
                end
                idx_d = idx_inc;
                if (idx_inc == IdxW'(BufferDepth)) begin
                  for (int i = 0; i < DecodeBytes; i++) begin
                    store_d[i] = '0;
                  end
                  in_frame_d = 1'b0;
                end
              end
            end
            if (cmd_i.is_start && !in_frame_d) begin
              in_frame_d = 1'b1;
              idx_d      = '0;
            end
          end
        end
        CMD_ACK:   ready_d = 1'b0;
        CMD_CLEAR: class_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DecodeBytes; i++) begin
        store_q[i] <= '0;
      end
      idx_q      <= '0;
      in_frame_q <= 1'b0;
      ready_q    <= 1'b0;
      value_q    <= '0;
      class_q    <= '0;
    end else begin
      store_q    <= store_d;
      idx_q      <= idx_d;
      in_frame_q <= in_frame_d;
      ready_q    <= ready_d;
      value_q    <= value_d;
      class_q    <= class_d;
    end
  end

  always_comb begin
    res_in.frame_ready = ready_d;
    res_in.value       = value_d;
    res_in.class_code  = class_d;
    res_in.collecting  = in_frame_d;
  end

  mfvd_fifo #(
    .Width ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (exec),
    .data_i  (res_in),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (res_raw),
    .empty_o (empty_o)
  );

  assign res_o = res_t'(res_raw);

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(BufferDepth))
    else $error("write index beyond buffer depth");

  a_frame_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (idx_q < IdxW'(BufferDepth)))
    else $error("open frame with a full buffer");

  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cmd_i.kind == CMD_BYTE && ready_q)
    |=> ($stable(in_frame_q) && $stable(idx_q) && ready_q))
    else $error("byte changed frame state while a frame was pending");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && cmd_i.kind == CMD_BYTE && !ready_q && in_frame_q && !cmd_i.is_end
     && !cmd_i.is_start && idx_inc == IdxW'(BufferDepth))
    |=> (!in_frame_q && store_q[0] == '0 && store_q[1] == '0))
    else $error("overflow did not abort the frame");

endmodule

`default_nettype wire
